/* sv/blcg_pkg.sv */
// Shared constants for the backlight curve and gating block.
package blcg_pkg;

  // Configuration register indexes.
  localparam logic [1:0] REG_MIN_LEVEL  = 2'd0;
  localparam logic [1:0] REG_MAX_LEVEL  = 2'd1;
  localparam logic [1:0] REG_CURVE_MODE = 2'd2;

  // Curve selection codes.
  localparam logic [1:0] CURVE_LINEAR   = 2'd0;
  localparam logic [1:0] CURVE_CONIC    = 2'd1;
  localparam logic [1:0] CURVE_POLYLINE = 2'd2;
  localparam logic [1:0] CURVE_RAW      = 2'd3;

  // Blend weights of the polyline curve, in percent.
  localparam int unsigned LINE_PERCENT = 45;
  localparam int unsigned FULL_PERCENT = 100;

  // Reset value of the maximum level register.
  localparam int unsigned MAX_LEVEL_RESET = 255;

endpackage

/* sv/backlight_curve_and_gating.sv */
// Backlight level mapping through a selectable curve, gating and enable pulse control.
//
// Usage: each input transfer carries a requested level and the power, unblank,
// forced-off and suspend flags. The block answers every input transfer with
// exactly one result transfer holding the write flag, the final level and the
// enable/re-init pulses. Both channels use valid/stall; the configuration
// channel (valid/ready, always ready) writes min_level, max_level and
// curve_mode by index and should be used only while the block is idle.
// Linear, raw, gated and ignored items, and conic items on an empty window, go
// straight from the input transfer to the final step. The conic curve runs the
// square and a division, and the polyline curve adds two blend steps and a second
// division (on an empty window only the blend steps and their division); both
// curves use the one shared multiplier. The bit-serial restoring divider makes
// one quotient bit per cycle over DW bits, 2*LEVEL_BITS or LEVEL_BITS+7 whichever
// is larger. The next input transfer can come in the cycle after the result loads.
// One item is processed at a time; in_stall is high while an item is in work.
// A finished result waits in the output register while out_stall is high;
// a new item may be accepted meanwhile, and its result holds in the final
// step until the output register frees up.
// Reset clears the state flags (lit off, enabled on, no suspend seen) and
// loads min_level 0, max_level 255 and the linear curve.
module backlight_curve_and_gating #(
  parameter int LEVEL_BITS = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Input channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [LEVEL_BITS-1:0] in_requested_level,
  input  logic                  in_power_on,
  input  logic                  in_unblanked,
  input  logic                  in_forced_off,
  input  logic                  in_suspend_request,
  // Result channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_write_valid,
  output logic [LEVEL_BITS-1:0] out_level,
  output logic                  out_pwm_on,
  output logic                  out_pwm_off,
  output logic                  out_reinit,
  // Configuration channel
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [1:0]            cfg_index,
  input  logic [LEVEL_BITS-1:0] cfg_data
);

  localparam int L  = LEVEL_BITS;
  // Multiplier operand and divisor width.
  localparam int MW = (L > 7) ? L : 7;
  // Dividend and quotient width.
  localparam int DW = (2 * L > L + 7) ? 2 * L : L + 7;
  localparam int CW = $clog2(DW);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_DIV,
    ST_BLEND_LO,
    ST_BLEND_HI,
    ST_FINISH
  } state_t;

  // Control and configuration registers
  state_t         state_r, state_nxt;
  logic [L-1:0]   min_level_r, min_level_nxt;
  logic [L-1:0]   max_level_r, max_level_nxt;
  logic [1:0]     curve_mode_r, curve_mode_nxt;
  logic           susp_seen_r, susp_seen_nxt;
  logic           lit_r, lit_nxt;
  logic           enabled_r, enabled_nxt;
  logic           out_valid_r, out_valid_nxt;

  // Result payload registers
  logic           wr_r, wr_nxt;
  logic [L-1:0]   out_level_r, out_level_nxt;
  logic           on_r, on_nxt;
  logic           off_r, off_nxt;
  logic           init_r, init_nxt;

  // Working registers of the sequencer
  logic [L-1:0]   req_r, req_nxt;
  logic           susp_req_r, susp_req_nxt;
  logic           ignore_r, ignore_nxt;
  logic [L-1:0]   d_r, d_nxt;
  logic [L-1:0]   level_r, level_nxt;
  logic [DW-1:0]  quo_r, quo_nxt;
  logic [MW-1:0]  rem_r, rem_nxt;
  logic [MW-1:0]  den_r, den_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic           blend_div_r, blend_div_nxt;

  // Window and curve helpers
  logic [L-1:0]   hi_level;
  logic [L-1:0]   span;
  logic [L-1:0]   req_floor;
  logic [L-1:0]   req_clamp;
  logic           gate_zero;
  logic           in_accept;

  // Shared multiplier
  logic [MW-1:0]   mul_a;
  logic [MW-1:0]   mul_b;
  logic [2*MW-1:0] prod;

  // Divider step
  logic [MW:0]    rem_sh;
  logic           div_ge;
  logic [MW:0]    rem_sub;
  logic [MW-1:0]  rem_step;
  logic [DW-1:0]  quo_step;
  logic [L-1:0]   conic_level;

  // Lit/enable decision for the finishing item
  logic           fin_wr;
  logic           fin_on;
  logic           fin_off;
  logic           fin_lit;
  logic           fin_en;

  assign in_stall  = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign in_accept = in_valid && !in_stall;

  assign out_valid       = out_valid_r;
  assign out_write_valid = wr_r;
  assign out_level       = out_level_r;
  assign out_pwm_on      = on_r;
  assign out_pwm_off     = off_r;
  assign out_reinit      = init_r;

  // Effective window and the request placed against it.
  always_comb begin
    hi_level  = (max_level_r < min_level_r) ? min_level_r : max_level_r;
    span      = hi_level - min_level_r;
    req_floor = (in_requested_level < min_level_r) ? min_level_r : in_requested_level;
    req_clamp = (req_floor > hi_level) ? hi_level : req_floor;
    gate_zero = !in_power_on || !in_unblanked || in_forced_off ||
                in_suspend_request || (in_requested_level == '0);
  end

  // Multiplier operand selection per sequencer step.
  always_comb begin
    mul_a = MW'(d_r);
    mul_b = MW'(d_r);
    case (state_r)
      ST_BLEND_LO: begin
        mul_a = MW'(blcg_pkg::LINE_PERCENT);
        mul_b = MW'(req_r);
      end
      ST_BLEND_HI: begin
        mul_a = MW'(blcg_pkg::FULL_PERCENT - blcg_pkg::LINE_PERCENT);
        mul_b = MW'(level_r);
      end
      default: begin
        mul_a = MW'(d_r);
        mul_b = MW'(d_r);
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  // One restoring division step; the remainder stays below the divisor.
  always_comb begin
    rem_sh   = {rem_r, quo_r[DW-1]};
    div_ge   = (rem_sh >= {1'b0, den_r});
    rem_sub  = rem_sh - {1'b0, den_r};
    rem_step = div_ge ? rem_sub[MW-1:0] : rem_sh[MW-1:0];
    quo_step = {quo_r[DW-2:0], div_ge};
    // The conic result passes the maximum exactly when the quotient exceeds the span.
    conic_level = (quo_step > DW'(span)) ? hi_level : (min_level_r + quo_step[L-1:0]);
  end

  // Lit and enable transitions for the item in its final step.
  always_comb begin
    fin_wr  = 1'b0;
    fin_on  = 1'b0;
    fin_off = 1'b0;
    fin_lit = lit_r;
    fin_en  = enabled_r;
    if (lit_r && (level_r == '0)) begin
      fin_off = 1'b1;
      fin_lit = 1'b0;
      fin_en  = 1'b0;
    end else if (!lit_r && (level_r != '0)) begin
      fin_on  = 1'b1;
      fin_wr  = 1'b1;
      fin_lit = 1'b1;
      fin_en  = 1'b1;
    end else begin
      fin_wr = enabled_r;
    end
  end

  // Sequencer next-state logic.
  always_comb begin
    state_nxt      = state_r;
    min_level_nxt  = min_level_r;
    max_level_nxt  = max_level_r;
    curve_mode_nxt = curve_mode_r;
    susp_seen_nxt  = susp_seen_r;
    lit_nxt        = lit_r;
    enabled_nxt    = enabled_r;
    out_valid_nxt  = out_valid_r;
    wr_nxt         = wr_r;
    out_level_nxt  = out_level_r;
    on_nxt         = on_r;
    off_nxt        = off_r;
    init_nxt       = init_r;
    req_nxt        = req_r;
    susp_req_nxt   = susp_req_r;
    ignore_nxt     = ignore_r;
    d_nxt          = d_r;
    level_nxt      = level_r;
    quo_nxt        = quo_r;
    rem_nxt        = rem_r;
    den_nxt        = den_r;
    cnt_nxt        = cnt_r;
    blend_div_nxt  = blend_div_r;

    // Configuration writes; an unknown index is dropped.
    if (cfg_valid) begin
      case (cfg_index)
        blcg_pkg::REG_MIN_LEVEL:  min_level_nxt  = cfg_data;
        blcg_pkg::REG_MAX_LEVEL:  max_level_nxt  = cfg_data;
        blcg_pkg::REG_CURVE_MODE: curve_mode_nxt = cfg_data[1:0];
        default: ;
      endcase
    end

    // The output register empties on a transfer.
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          req_nxt       = in_requested_level;
          susp_req_nxt  = in_suspend_request;
          ignore_nxt    = susp_seen_r && in_suspend_request;
          blend_div_nxt = 1'b0;
          d_nxt         = req_floor - min_level_r;
          level_nxt     = '0;
          state_nxt     = ST_FINISH;
          if (!(susp_seen_r && in_suspend_request) && !gate_zero) begin
            case (curve_mode_r)
              blcg_pkg::CURVE_LINEAR: level_nxt = req_clamp;
              blcg_pkg::CURVE_RAW:    level_nxt = in_requested_level;
              blcg_pkg::CURVE_CONIC,
              blcg_pkg::CURVE_POLYLINE: begin
                if (span == '0) begin
                  // Empty window: the conic curve sits at the minimum.
                  level_nxt = min_level_r;
                  if (curve_mode_r == blcg_pkg::CURVE_POLYLINE) begin
                    state_nxt = ST_BLEND_LO;
                  end
                end else begin
                  state_nxt = ST_SQUARE;
                end
              end
              default: level_nxt = in_requested_level;
            endcase
          end
        end
      end

      ST_SQUARE: begin
        quo_nxt   = DW'(prod);
        rem_nxt   = '0;
        den_nxt   = MW'(span);
        cnt_nxt   = '0;
        state_nxt = ST_DIV;
      end

      ST_DIV: begin
        quo_nxt = quo_step;
        rem_nxt = rem_step;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CW'(DW - 1)) begin
          if (blend_div_r) begin
            level_nxt = quo_step[L-1:0];
            state_nxt = ST_FINISH;
          end else begin
            level_nxt = conic_level;
            state_nxt = (curve_mode_r == blcg_pkg::CURVE_CONIC) ? ST_FINISH : ST_BLEND_LO;
          end
        end
      end

      ST_BLEND_LO: begin
        quo_nxt   = DW'(prod);
        state_nxt = ST_BLEND_HI;
      end

      ST_BLEND_HI: begin
        quo_nxt       = quo_r + DW'(prod);
        rem_nxt       = '0;
        den_nxt       = MW'(blcg_pkg::FULL_PERCENT);
        cnt_nxt       = '0;
        blend_div_nxt = 1'b1;
        state_nxt     = ST_DIV;
      end

      ST_FINISH: begin
        // Load the result once the output register is free or leaving.
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
          if (ignore_r) begin
            wr_nxt        = 1'b0;
            out_level_nxt = '0;
            on_nxt        = 1'b0;
            off_nxt       = 1'b0;
            init_nxt      = 1'b0;
          end else begin
            wr_nxt        = fin_wr;
            out_level_nxt = level_r;
            on_nxt        = fin_on;
            off_nxt       = fin_off;
            init_nxt      = fin_on;
            lit_nxt       = fin_lit;
            enabled_nxt   = fin_en;
            susp_seen_nxt = susp_req_r;
          end
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  // State, configuration and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      min_level_r  <= '0;
      max_level_r  <= L'(blcg_pkg::MAX_LEVEL_RESET);
      curve_mode_r <= blcg_pkg::CURVE_LINEAR;
      susp_seen_r  <= 1'b0;
      lit_r        <= 1'b0;
      enabled_r    <= 1'b1;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      min_level_r  <= min_level_nxt;
      max_level_r  <= max_level_nxt;
      curve_mode_r <= curve_mode_nxt;
      susp_seen_r  <= susp_seen_nxt;
      lit_r        <= lit_nxt;
      enabled_r    <= enabled_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    wr_r        <= wr_nxt;
    out_level_r <= out_level_nxt;
    on_r        <= on_nxt;
    off_r       <= off_nxt;
    init_r      <= init_nxt;
    req_r       <= req_nxt;
    susp_req_r  <= susp_req_nxt;
    ignore_r    <= ignore_nxt;
    d_r         <= d_nxt;
    level_r     <= level_nxt;
    quo_r       <= quo_nxt;
    rem_r       <= rem_nxt;
    den_r       <= den_nxt;
    cnt_r       <= cnt_nxt;
    blend_div_r <= blend_div_nxt;
  end

endmodule

/* dv/tb_top.sv */
// Self-checking testbench for the backlight curve and gating block.
`timescale 1ns / 1ps

module tb_top;

  localparam int LEVEL_BITS = 8;
  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam int HOLD_OFF_CYCLES = 400;

  // One result transfer of the block, as predicted or as observed.
  typedef struct packed {
    logic                  write_valid;
    logic [LEVEL_BITS-1:0] level;
    logic                  pwm_on;
    logic                  pwm_off;
    logic                  reinit;
  } gated_result_t;

  // Tracks the block's registers and state flags and checks every result in order.
  class backlight_scoreboard;
    logic [LEVEL_BITS-1:0] min_lvl;
    logic [LEVEL_BITS-1:0] max_lvl;
    logic [1:0]            curve;
    logic                  suspended_seen;
    logic                  lit;
    logic                  enabled;
    gated_result_t         expected_levels[$];
    int                    errors;
    int                    results_checked;

    function new();
      min_lvl        = '0;
      max_lvl        = LEVEL_BITS'(blcg_pkg::MAX_LEVEL_RESET);
      curve          = blcg_pkg::CURVE_LINEAR;
      suspended_seen = 1'b0;
      lit            = 1'b0;
      enabled        = 1'b1;
      errors         = 0;
      results_checked = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [LEVEL_BITS-1:0] data);
      case (idx)
        blcg_pkg::REG_MIN_LEVEL:  min_lvl = data;
        blcg_pkg::REG_MAX_LEVEL:  max_lvl = data;
        blcg_pkg::REG_CURVE_MODE: curve = data[1:0];
        default: ;
      endcase
    endfunction

    function int unsigned clamp_level(int unsigned v, int unsigned lo, int unsigned hi);
      if (v > hi) return hi;
      if (v < lo) return lo;
      return v;
    endfunction

    // Squared excess over the minimum, scaled by the window width.
    function int unsigned conic_level(int unsigned r, int unsigned lo, int unsigned hi);
      int unsigned d;
      if (r < lo) r = lo;
      if (hi == lo) return lo;
      d = r - lo;
      return clamp_level((d * d) / (hi - lo) + lo, lo, hi);
    endfunction

    function logic [LEVEL_BITS-1:0] curve_level(logic [LEVEL_BITS-1:0] r);
      int unsigned lo;
      int unsigned hi;
      int unsigned c;
      lo = min_lvl;
      hi = (max_lvl < min_lvl) ? min_lvl : max_lvl;
      case (curve)
        blcg_pkg::CURVE_LINEAR:   c = clamp_level(r, lo, hi);
        blcg_pkg::CURVE_CONIC:    c = conic_level(r, lo, hi);
        blcg_pkg::CURVE_POLYLINE: c = (r * blcg_pkg::LINE_PERCENT +
                                       conic_level(r, lo, hi) *
                                       (blcg_pkg::FULL_PERCENT - blcg_pkg::LINE_PERCENT)) /
                                      blcg_pkg::FULL_PERCENT;
        default:                  c = r;
      endcase
      return c[LEVEL_BITS-1:0];
    endfunction

    // Works out the result of one accepted update and queues it.
    function void note_update(logic [LEVEL_BITS-1:0] req, logic pwr, logic unb,
                              logic forced, logic susp);
      gated_result_t         r;
      logic [LEVEL_BITS-1:0] lvl;
      r = '0;
      // A repeated suspend request is dropped with an all-zero result.
      if (suspended_seen && susp) begin
        expected_levels.push_back(r);
        return;
      end
      lvl = '0;
      if (req != '0) lvl = curve_level(req);
      if (!pwr || !unb || forced) lvl = '0;
      if (susp) begin
        lvl = '0;
        suspended_seen = 1'b1;
      end else begin
        suspended_seen = 1'b0;
      end
      if (lit && lvl == '0) begin
        lit       = 1'b0;
        enabled   = 1'b0;
        r.pwm_off = 1'b1;
      end else if (!lit && lvl != '0) begin
        lit           = 1'b1;
        enabled       = 1'b1;
        r.pwm_on      = 1'b1;
        r.reinit      = 1'b1;
        r.write_valid = 1'b1;
      end else if (enabled) begin
        r.write_valid = 1'b1;
      end
      r.level = lvl;
      expected_levels.push_back(r);
    endfunction

    function void compare_field(string name, int unsigned exp_v, int unsigned act_v);
      if (exp_v != act_v) begin
        $display("%0t: result %0d field %s mismatch: expected %0d, actual %0d",
                 $time, results_checked, name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_result(logic wr, logic [LEVEL_BITS-1:0] lvl, logic on,
                               logic off, logic init);
      gated_result_t e;
      if (expected_levels.size() == 0) begin
        $display("%0t: unexpected result: level %0d with no update outstanding",
                 $time, lvl);
        errors++;
        return;
      end
      e = expected_levels.pop_front();
      compare_field("write_valid", e.write_valid, wr);
      compare_field("level", e.level, lvl);
      compare_field("pwm_on", e.pwm_on, on);
      compare_field("pwm_off", e.pwm_off, off);
      compare_field("reinit", e.reinit, init);
      results_checked++;
    endfunction

    function int pending_count();
      return expected_levels.size();
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic [LEVEL_BITS-1:0] in_requested_level;
  logic                  in_power_on;
  logic                  in_unblanked;
  logic                  in_forced_off;
  logic                  in_suspend_request;
  logic                  out_valid;
  logic                  out_stall;
  logic                  out_write_valid;
  logic [LEVEL_BITS-1:0] out_level;
  logic                  out_pwm_on;
  logic                  out_pwm_off;
  logic                  out_reinit;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [1:0]            cfg_index;
  logic [LEVEL_BITS-1:0] cfg_data;

  backlight_scoreboard sb;
  int   updates_sent;
  int   cfg_writes;
  int   settings_used;
  int   burst_left;
  logic hold_off;
  logic toggle_stall;
  int   stall_mode;
  int   stall_len;

  backlight_curve_and_gating #(.LEVEL_BITS(LEVEL_BITS)) uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_requested_level (in_requested_level),
    .in_power_on        (in_power_on),
    .in_unblanked       (in_unblanked),
    .in_forced_off      (in_forced_off),
    .in_suspend_request (in_suspend_request),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_write_valid    (out_write_valid),
    .out_level          (out_level),
    .out_pwm_on         (out_pwm_on),
    .out_pwm_off        (out_pwm_off),
    .out_reinit         (out_reinit),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Offers one update in the current burst, opening a new burst after a random gap.
  task automatic send_update(input logic [LEVEL_BITS-1:0] req, input logic pwr,
                             input logic unb, input logic forced, input logic susp);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 12);
      if (gap != 0) begin
        @(negedge clk);
        in_valid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    @(negedge clk);
    in_valid           = 1'b1;
    in_requested_level = req;
    in_power_on        = pwr;
    in_unblanked       = unb;
    in_forced_off      = forced;
    in_suspend_request = susp;
    do @(posedge clk); while (in_stall);
    sb.note_update(req, pwr, unb, forced, susp);
    updates_sent++;
    burst_left--;
  endtask

  // Stops offering updates and waits until every expected result has been transferred.
  task automatic drain_results();
    @(negedge clk);
    in_valid   = 1'b0;
    burst_left = 0;
    while (sb.pending_count() != 0) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [1:0] idx, input logic [LEVEL_BITS-1:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
    cfg_writes++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Loads a new curve setting once the block is idle.
  task automatic apply_curve(input logic [LEVEL_BITS-1:0] lo, input logic [LEVEL_BITS-1:0] hi,
                             input logic [1:0] mode);
    drain_results();
    write_cfg(blcg_pkg::REG_MIN_LEVEL, lo);
    write_cfg(blcg_pkg::REG_MAX_LEVEL, hi);
    write_cfg(blcg_pkg::REG_CURVE_MODE, {{(LEVEL_BITS-2){1'b0}}, mode});
    // Writes to the unused index must leave the setting alone.
    if ($urandom_range(0, 2) == 0) write_cfg(REG_UNUSED, LEVEL_BITS'($urandom));
    settings_used++;
  endtask

  // One random update: mostly well-formed lit requests, some suspend runs, some noise.
  task automatic random_update();
    int kind;
    int sel;
    int n;
    logic [LEVEL_BITS-1:0] req;
    sel = $urandom_range(0, 9);
    if (sel == 0) req = '0;
    else if (sel == 1) req = '1;
    else if (sel == 2) req = LEVEL_BITS'($urandom_range(0, 15));
    else req = LEVEL_BITS'($urandom);
    kind = $urandom_range(0, 99);
    if (kind < 70) begin
      send_update(req, 1'b1, 1'b1, 1'b0, 1'b0);
    end else if (kind < 80) begin
      n = $urandom_range(1, 3);
      repeat (n) send_update(req, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                             1'($urandom_range(0, 1)), 1'b1);
    end else begin
      send_update(req, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    end
  endtask

  // Result monitor.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result(out_write_valid, out_level, out_pwm_on, out_pwm_off, out_reinit);
  end

  // Receiver stall pattern: runs of no stall, light, heavy and alternating stall.
  initial begin
    out_stall    = 1'b0;
    toggle_stall = 1'b0;
    forever begin
      stall_mode = $urandom_range(0, 3);
      stall_len  = $urandom_range(20, 200);
      repeat (stall_len) begin
        @(negedge clk);
        toggle_stall = ~toggle_stall;
        case (stall_mode)
          0:       out_stall = hold_off;
          1:       out_stall = hold_off | ($urandom_range(0, 3) == 0);
          2:       out_stall = hold_off | ($urandom_range(0, 3) != 0);
          default: out_stall = hold_off | toggle_stall;
        endcase
      end
    end
  end

  // Long receiver hold-off in the middle of a phase so the block backs up into its input.
  initial begin
    hold_off = 1'b0;
    wait (updates_sent >= 150);
    @(posedge clk);
    hold_off = 1'b1;
    repeat (HOLD_OFF_CYCLES) @(posedge clk);
    hold_off = 1'b0;
  end

  // Overall time limit.
  initial begin
    #1000000;
    $display("%0t: timeout with %0d results outstanding", $time, sb.pending_count());
    $display("RESULT: ERROR");
    $finish;
  end

  // Main sequence.
  initial begin
    sb                 = new();
    updates_sent       = 0;
    cfg_writes         = 0;
    settings_used      = 1;
    burst_left         = 0;
    rst_n              = 1'b0;
    in_valid           = 1'b0;
    in_requested_level = '0;
    in_power_on        = 1'b0;
    in_unblanked       = 1'b0;
    in_forced_off      = 1'b0;
    in_suspend_request = 1'b0;
    cfg_valid          = 1'b0;
    cfg_index          = blcg_pkg::REG_MIN_LEVEL;
    cfg_data           = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: reset setting, gating flags, lit and dark transitions, suspend handling.
    send_update(8'd0,   1'b1, 1'b1, 1'b0, 1'b0);
    send_update(8'd255, 1'b1, 1'b1, 1'b0, 1'b0);
    send_update(8'd1,   1'b1, 1'b1, 1'b0, 1'b0);
    send_update(8'd200, 1'b0, 1'b1, 1'b0, 1'b0);
    send_update(8'd100, 1'b1, 1'b1, 1'b0, 1'b0);
    send_update(8'd100, 1'b1, 1'b0, 1'b0, 1'b0);
    send_update(8'd0,   1'b1, 1'b1, 1'b0, 1'b0);
    send_update(8'd50,  1'b1, 1'b1, 1'b1, 1'b0);
    send_update(8'd80,  1'b1, 1'b1, 1'b0, 1'b1);
    send_update(8'd80,  1'b1, 1'b1, 1'b0, 1'b1);
    send_update(8'd0,   1'b0, 1'b0, 1'b1, 1'b1);
    send_update(8'd170, 1'b1, 1'b1, 1'b0, 1'b0);
    send_update(8'd170, 1'b1, 1'b1, 1'b0, 1'b1);
    send_update(8'd85,  1'b1, 1'b1, 1'b0, 1'b0);
    // Empty window on the conic curve.
    apply_curve(8'd100, 8'd100, blcg_pkg::CURVE_CONIC);
    send_update(8'd50,  1'b1, 1'b1, 1'b0, 1'b0);
    send_update(8'd200, 1'b1, 1'b1, 1'b0, 1'b0);
    send_update(8'd0,   1'b1, 1'b1, 1'b0, 1'b0);
    // Maximum below minimum on the polyline blend.
    apply_curve(8'd200, 8'd50, blcg_pkg::CURVE_POLYLINE);
    send_update(8'd10,  1'b1, 1'b1, 1'b0, 1'b0);
    send_update(8'd255, 1'b1, 1'b1, 1'b0, 1'b0);
    apply_curve(8'd16, 8'd240, blcg_pkg::CURVE_CONIC);
    send_update(8'd240, 1'b1, 1'b1, 1'b0, 1'b0);
    send_update(8'd17,  1'b1, 1'b1, 1'b0, 1'b0);
    apply_curve(8'd30, 8'd60, blcg_pkg::CURVE_RAW);
    write_cfg(REG_UNUSED, 8'hA5);
    send_update(8'd5,   1'b1, 1'b1, 1'b0, 1'b0);
    send_update(8'd255, 1'b1, 1'b1, 1'b0, 1'b0);

    // Random phases: extreme settings first, then random ones.
    for (int phase = 0; phase < 10; phase++) begin
      case (phase)
        0:       apply_curve(8'd0,   8'd255, blcg_pkg::CURVE_LINEAR);
        1:       apply_curve(8'd0,   8'd255, blcg_pkg::CURVE_CONIC);
        2:       apply_curve(8'd0,   8'd255, blcg_pkg::CURVE_POLYLINE);
        3:       apply_curve(8'd255, 8'd255, blcg_pkg::CURVE_RAW);
        4:       apply_curve(8'd128, 8'd128, blcg_pkg::CURVE_CONIC);
        5:       apply_curve(8'd200, 8'd40,  blcg_pkg::CURVE_POLYLINE);
        6:       apply_curve(8'd0,   8'd0,   blcg_pkg::CURVE_LINEAR);
        default: apply_curve(LEVEL_BITS'($urandom), LEVEL_BITS'($urandom),
                             2'($urandom_range(0, 3)));
      endcase
      repeat (50) random_update();
    end

    drain_results();
    repeat (60) @(posedge clk);
    if (sb.pending_count() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, sb.pending_count());
      sb.errors++;
    end
    $display("Checked %0d results from %0d level updates over %0d curve settings",
             sb.results_checked, updates_sent, settings_used);
    $display("(%0d register writes, one %0d-cycle receiver hold-off), %0d mismatches",
             cfg_writes, HOLD_OFF_CYCLES, sb.errors);
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
